// ----- src/pcdc_pkg.sv -----
package pcdc_pkg;

  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;
  localparam int unsigned CurW   = 16;
  localparam int unsigned GainW  = 24;
  localparam int unsigned DutyW  = 16;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned ErrW   = CurW + 1;
  localparam int unsigned IntegW = 32;
  localparam int unsigned PropW  = GainW + 1 + ErrW + 1;
  localparam int unsigned IprodW = GainW + 1 + IntegW;
  localparam int unsigned SumW   = IprodW + 1;
  localparam int unsigned FracW  = 16;
  localparam int unsigned RawW   = SumW - FracW;

  localparam logic [DutyW-1:0] FLOOR_RST = DutyW'(100);
  localparam logic [DutyW-1:0] CEIL_RST  = DutyW'(4900);

  typedef enum logic [ModeW-1:0] {
    MODE_BUCK  = 2'd0,
    MODE_BOOST = 2'd1,
    MODE_H2    = 2'd2,
    MODE_RSVD  = 2'd3
  } mode_t;

  localparam logic [2:0] REG_SETPOINT = 3'd0;
  localparam logic [2:0] REG_PROP     = 3'd1;
  localparam logic [2:0] REG_INTEG    = 3'd2;
  localparam logic [2:0] REG_MODE     = 3'd3;
  localparam logic [2:0] REG_FLOOR    = 3'd4;
  localparam logic [2:0] REG_CEIL     = 3'd5;

  typedef struct packed {
    logic signed [CurW-1:0] setpoint;
    logic [GainW-1:0]       prop_gain;
    logic [GainW-1:0]       integ_gain;
    mode_t                  mode;
    logic [DutyW-1:0]       duty_floor;
    logic [DutyW-1:0]       duty_ceiling;
  } cfg_t;

endpackage

// ----- src/pcdc_regs.sv -----
module pcdc_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pcdc_pkg::AddrW-1:0]  paddr,
  input  logic [pcdc_pkg::DataW-1:0]  pwdata,
  output logic [pcdc_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  output pcdc_pkg::cfg_t              cfg
);
  import pcdc_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[AddrW-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_SETPOINT: cfg_nxt.setpoint     = pwdata[CurW-1:0];
        REG_PROP:     cfg_nxt.prop_gain    = pwdata[GainW-1:0];
        REG_INTEG:    cfg_nxt.integ_gain   = pwdata[GainW-1:0];
        REG_MODE:     cfg_nxt.mode         = mode_t'(pwdata[ModeW-1:0]);
        REG_FLOOR:    cfg_nxt.duty_floor   = pwdata[DutyW-1:0];
        REG_CEIL:     cfg_nxt.duty_ceiling = pwdata[DutyW-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SETPOINT: prdata = DataW'(cfg_r.setpoint);
      REG_PROP:     prdata = DataW'(cfg_r.prop_gain);
      REG_INTEG:    prdata = DataW'(cfg_r.integ_gain);
      REG_MODE:     prdata = DataW'(cfg_r.mode);
      REG_FLOOR:    prdata = DataW'(cfg_r.duty_floor);
      REG_CEIL:     prdata = DataW'(cfg_r.duty_ceiling);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setpoint     <= '0;
      cfg_r.prop_gain    <= '0;
      cfg_r.integ_gain   <= '0;
      cfg_r.mode         <= MODE_BUCK;
      cfg_r.duty_floor   <= FLOOR_RST;
      cfg_r.duty_ceiling <= CEIL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- src/pcdc_integ.sv -----
module pcdc_integ (
  input  logic                               clk,
  input  logic                               rst_n,
  input  pcdc_pkg::cfg_t                     cfg,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [pcdc_pkg::CurW-1:0]   in_meas,
  output logic                               err_valid,
  input  logic                               err_ready,
  output logic signed [pcdc_pkg::ErrW-1:0]   err,
  output logic signed [pcdc_pkg::IntegW-1:0] integ
);
  import pcdc_pkg::*;

  localparam logic signed [IntegW:0] IntMax = (IntegW+1)'((64'sd1 <<< (IntegW-1)) - 1);
  localparam logic signed [IntegW:0] IntMin = -(IntegW+1)'(64'sd1 <<< (IntegW-1));

  logic                     vld_r;
  logic signed [ErrW-1:0]   err_r;
  logic signed [ErrW-1:0]   err_nxt;
  logic signed [IntegW-1:0] integ_r;
  logic signed [IntegW-1:0] integ_nxt;
  logic signed [IntegW:0]   acc;
  logic                     take;

  assign in_ready  = !vld_r || err_ready;
  assign take      = in_valid && in_ready;
  assign err_valid = vld_r;
  assign err       = err_r;
  assign integ     = integ_r;

  always_comb begin
    if (cfg.mode == MODE_BOOST) begin
      err_nxt = ErrW'(cfg.setpoint) + ErrW'(in_meas);
    end else begin
      err_nxt = ErrW'(cfg.setpoint) - ErrW'(in_meas);
    end
    acc = (IntegW+1)'(integ_r) + (IntegW+1)'(err_nxt);
    if (acc > IntMax) begin
      integ_nxt = IntMax[IntegW-1:0];
    end else if (acc < IntMin) begin
      integ_nxt = IntMin[IntegW-1:0];
    end else begin
      integ_nxt = acc[IntegW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= 1'b0;
      integ_r <= '0;
    end else begin
      if (in_ready) begin
        vld_r <= in_valid;
      end
      if (take) begin
        integ_r <= integ_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      err_r <= err_nxt;
    end
  end

endmodule

// ----- src/pcdc_gain.sv -----
module pcdc_gain (
  input  logic                               clk,
  input  logic                               rst_n,
  input  pcdc_pkg::cfg_t                     cfg,
  input  logic                               err_valid,
  output logic                               err_ready,
  input  logic signed [pcdc_pkg::ErrW-1:0]   err,
  input  logic signed [pcdc_pkg::IntegW-1:0] integ,
  output logic                               prod_valid,
  input  logic                               prod_ready,
  output logic signed [pcdc_pkg::PropW-1:0]  pprod,
  output logic signed [pcdc_pkg::IprodW-1:0] iprod
);
  import pcdc_pkg::*;

  logic                     vld_r;
  logic signed [PropW-1:0]  pprod_r;
  logic signed [IprodW-1:0] iprod_r;
  logic signed [PropW-1:0]  kp_ext;
  logic signed [PropW-1:0]  err_ext;
  logic signed [IprodW-1:0] ki_ext;
  logic signed [IprodW-1:0] integ_ext;
  logic                     take;

  assign err_ready  = !vld_r || prod_ready;
  assign take       = err_valid && err_ready;
  assign prod_valid = vld_r;
  assign pprod      = pprod_r;
  assign iprod      = iprod_r;

  assign kp_ext    = signed'(PropW'(cfg.prop_gain));
  assign err_ext   = PropW'(err);
  assign ki_ext    = signed'(IprodW'(cfg.integ_gain));
  assign integ_ext = IprodW'(integ);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (err_ready) begin
      vld_r <= err_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pprod_r <= kp_ext * err_ext;
      iprod_r <= ki_ext * integ_ext;
    end
  end

endmodule

// ----- src/pcdc_clamp.sv -----
module pcdc_clamp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  pcdc_pkg::cfg_t                     cfg,
  input  logic                               prod_valid,
  output logic                               prod_ready,
  input  logic signed [pcdc_pkg::PropW-1:0]  pprod,
  input  logic signed [pcdc_pkg::IprodW-1:0] iprod,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [pcdc_pkg::DutyW-1:0]         out_duty,
  output logic                               out_clamped
);
  import pcdc_pkg::*;

  logic                   vld_r;
  logic [DutyW-1:0]       duty_r;
  logic [DutyW-1:0]       duty_nxt;
  logic                   clamp_r;
  logic                   clamp_nxt;
  logic signed [SumW-1:0] sum;
  logic signed [RawW-1:0] raw;
  logic signed [RawW-1:0] ceil_ext;
  logic signed [RawW-1:0] floor_ext;
  logic                   take;

  assign prod_ready  = !vld_r || out_ready;
  assign take        = prod_valid && prod_ready;
  assign out_valid   = vld_r;
  assign out_duty    = duty_r;
  assign out_clamped = clamp_r;

  // arithmetic shift gives floor division by 2^16
  assign sum       = SumW'(pprod) + SumW'(iprod);
  assign raw       = sum[SumW-1:FracW];
  assign ceil_ext  = signed'(RawW'(cfg.duty_ceiling));
  assign floor_ext = signed'(RawW'(cfg.duty_floor));

  always_comb begin
    if (raw > ceil_ext) begin
      duty_nxt  = cfg.duty_ceiling;
      clamp_nxt = 1'b1;
    end else if (raw < floor_ext) begin
      duty_nxt  = cfg.duty_floor;
      clamp_nxt = 1'b1;
    end else begin
      duty_nxt  = raw[DutyW-1:0];
      clamp_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (prod_ready) begin
      vld_r <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      duty_r  <= duty_nxt;
      clamp_r <= clamp_nxt;
    end
  end

endmodule

// ----- src/pi_current_duty_controller.sv -----
// Channel  Handshake                Payload
// in       in_valid / in_ready      in_measured_current (s16, Q8.8 A)
// out      out_valid / out_ready    out_duty_count (u16), out_was_clamped (u1)
// cfg      psel penable pwrite      paddr, pwdata, prdata; pready tied high
//
// Three register stages: error and integral, gain multiply, sum and clamp.
// One request per cycle while out_ready is high; out_valid follows the clamp register.
// The integral feedback closes in the first stage, a single 33-bit saturating add.
// Each stage holds while its successor is full and stalled; empty stages still fill.
// rst_n (sync) clears the integral, the stage valids and the registers to defaults.
module pi_current_duty_controller (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [pcdc_pkg::CurW-1:0]   in_measured_current,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [pcdc_pkg::DutyW-1:0]         out_duty_count,
  output logic                               out_was_clamped,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pcdc_pkg::AddrW-1:0]         paddr,
  input  logic [pcdc_pkg::DataW-1:0]         pwdata,
  output logic [pcdc_pkg::DataW-1:0]         prdata,
  output logic                               pready
);
  import pcdc_pkg::*;

  cfg_t                     cfg;
  logic                     err_valid;
  logic                     err_ready;
  logic signed [ErrW-1:0]   err;
  logic signed [IntegW-1:0] integ;
  logic                     prod_valid;
  logic                     prod_ready;
  logic signed [PropW-1:0]  pprod;
  logic signed [IprodW-1:0] iprod;

  pcdc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pcdc_integ u_integ (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_meas   (in_measured_current),
    .err_valid (err_valid),
    .err_ready (err_ready),
    .err       (err),
    .integ     (integ)
  );

  pcdc_gain u_gain (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .err_valid  (err_valid),
    .err_ready  (err_ready),
    .err        (err),
    .integ      (integ),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .pprod      (pprod),
    .iprod      (iprod)
  );

  pcdc_clamp u_clamp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .prod_valid  (prod_valid),
    .prod_ready  (prod_ready),
    .pprod       (pprod),
    .iprod       (iprod),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_duty    (out_duty_count),
    .out_clamped (out_was_clamped)
  );

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import pcdc_pkg::*;

  localparam longint INTEG_TOP    = 64'sd2147483647;
  localparam longint INTEG_BOTTOM = -64'sd2147483648;
  localparam logic [2:0] REG_SPARE0 = 3'd6;
  localparam logic [2:0] REG_SPARE1 = 3'd7;
  localparam logic [31:0] UNITY_GAIN = 32'd65536;
  localparam logic [31:0] HALF_GAIN  = 32'd32768;
  localparam int DRAIN_CYCLES = 6;
  localparam int CYCLE_LIMIT  = 10_000_000;

  typedef struct {
    logic [DutyW-1:0] duty;
    logic             clamped;
  } duty_result_t;

  typedef enum {RX_OPEN, RX_COIN, RX_RHYTHM, RX_HOLD} rx_pattern_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CurW-1:0] in_measured_current = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [DutyW-1:0] out_duty_count;
  logic out_was_clamped;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic pready;

  // controller copy
  logic signed [CurW-1:0]   setpoint_m = '0;
  logic [GainW-1:0]         kp_m = '0;
  logic [GainW-1:0]         ki_m = '0;
  mode_t                    mode_m = MODE_BUCK;
  logic [DutyW-1:0]         floor_m = FLOOR_RST;
  logic [DutyW-1:0]         ceil_m = CEIL_RST;
  logic signed [IntegW-1:0] integ_m = '0;

  logic signed [CurW-1:0] pending_meas[$];
  duty_result_t duty_expected[$];
  int errors = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int gap_left = 0;
  int rx_tick = 0;
  rx_pattern_t rx_pattern = RX_OPEN;

  pi_current_duty_controller DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_measured_current (in_measured_current),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_duty_count      (out_duty_count),
    .out_was_clamped     (out_was_clamped),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  always #5 clk = ~clk;

  task automatic report(input string msg);
    errors++;
    if (errors <= 100) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
  endtask

  function automatic void predict_duty(input logic signed [CurW-1:0] meas);
    longint err;
    longint acc;
    longint sum;
    longint raw;
    duty_result_t r;
    if (mode_m == MODE_BOOST) begin
      err = longint'(setpoint_m) + longint'(meas);
    end else begin
      err = longint'(setpoint_m) - longint'(meas);
    end
    acc = longint'(integ_m) + err;
    if (acc > INTEG_TOP) begin
      acc = INTEG_TOP;
    end else if (acc < INTEG_BOTTOM) begin
      acc = INTEG_BOTTOM;
    end
    integ_m = acc[IntegW-1:0];
    sum = longint'(kp_m) * err + longint'(ki_m) * acc;
    raw = sum >>> FracW;
    r.clamped = 1'b1;
    if (raw > longint'(ceil_m)) begin
      r.duty = ceil_m;
    end else if (raw < longint'(floor_m)) begin
      r.duty = floor_m;
    end else begin
      r.duty = raw[DutyW-1:0];
      r.clamped = 1'b0;
    end
    duty_expected.push_back(r);
  endfunction

  // setup cycle, access cycle; register takes the word at the access edge
  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] word);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SETPOINT: setpoint_m = word[CurW-1:0];
      REG_PROP:     kp_m = word[GainW-1:0];
      REG_INTEG:    ki_m = word[GainW-1:0];
      REG_MODE:     mode_m = mode_t'(word[ModeW-1:0]);
      REG_FLOOR:    floor_m = word[DutyW-1:0];
      REG_CEIL:     ceil_m = word[DutyW-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic drain();
    while (pending_meas.size() != 0 || in_valid || duty_expected.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // sender: bursts of requests separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0 || pending_meas.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        in_measured_current <= pending_meas.pop_front();
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          case ($urandom_range(0, 15))
            0, 1, 2, 3: gap_left = 0;
            15:         gap_left = $urandom_range(10, 20);
            default:    gap_left = $urandom_range(1, 5);
          endcase
        end
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (rx_tick % 50 == 0) rx_pattern = rx_pattern_t'($urandom_range(0, 3));
    case (rx_pattern)
      RX_OPEN:   out_ready <= 1'b1;
      RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RX_RHYTHM: out_ready <= (rx_tick % 5) < 3;
      default:   out_ready <= (rx_tick % 50) >= 10;
    endcase
    rx_tick++;
  end

  always @(posedge clk) begin
    duty_result_t want;
    if (rst_n) begin
      if (in_valid && in_ready) predict_duty(in_measured_current);
      if (out_valid && out_ready) begin
        if (duty_expected.size() == 0) begin
          report("result with no request outstanding");
        end else begin
          want = duty_expected.pop_front();
          if (out_duty_count !== want.duty) begin
            report($sformatf("duty_count %0d, expected %0d", out_duty_count, want.duty));
          end
          if (out_was_clamped !== want.clamped) begin
            report($sformatf("was_clamped %b, expected %b", out_was_clamped, want.clamped));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("pi_current_duty_controller verification failed");
      $finish;
    end
  end

  initial begin
    mode_t mode_seq[3];
    logic signed [CurW-1:0] noise;
    logic [31:0] kp_w;
    logic [31:0] ki_w;
    logic [15:0] lo_w;
    logic [15:0] hi_w;
    int n;
    mode_seq = '{MODE_BOOST, MODE_H2, MODE_RSVD};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset values: zero gains, raw 0 sits under the default floor
    pending_meas.push_back(16'sh8000);
    pending_meas.push_back(16'sh7fff);
    pending_meas.push_back(16'sh0000);
    drain();

    // unity gain: raw equals the error; limits hit exactly and just past
    cfg_write(REG_PROP, UNITY_GAIN);
    cfg_write(REG_SPARE0, $urandom());
    cfg_write(REG_SPARE1, $urandom());
    pending_meas.push_back(-16'sd100);
    pending_meas.push_back(-16'sd4900);
    pending_meas.push_back(-16'sd99);
    pending_meas.push_back(-16'sd4901);
    pending_meas.push_back(16'sd1);
    drain();

    // half gain: negative odd errors round toward minus infinity
    cfg_write(REG_PROP, HALF_GAIN);
    cfg_write(REG_FLOOR, 32'd0);
    cfg_write(REG_CEIL, 32'hABCD_FFFF);
    pending_meas.push_back(16'sd1);
    pending_meas.push_back(-16'sd1);
    pending_meas.push_back(-16'sd3);
    drain();

    foreach (mode_seq[i]) begin
      cfg_write(REG_MODE, 32'(mode_seq[i]));
      pending_meas.push_back(16'sd100);
      pending_meas.push_back(-16'sd100);
      drain();
    end

    // floor above ceiling
    cfg_write(REG_MODE, 32'(MODE_BUCK));
    cfg_write(REG_PROP, UNITY_GAIN);
    cfg_write(REG_FLOOR, 32'd5000);
    cfg_write(REG_CEIL, 32'd1000);
    pending_meas.push_back(-16'sd3000);
    pending_meas.push_back(-16'sd500);
    pending_meas.push_back(-16'sd2000);
    drain();

    cfg_write(REG_SETPOINT, 32'hFFFF_7FFF);
    cfg_write(REG_PROP, 32'hFFFF_FFFF);
    cfg_write(REG_INTEG, 32'hFFFF_FFFF);
    cfg_write(REG_MODE, 32'(MODE_BOOST));
    cfg_write(REG_FLOOR, 32'd65535);
    cfg_write(REG_CEIL, 32'd65535);
    pending_meas.push_back(16'sh8000);
    pending_meas.push_back(16'sh7fff);
    drain();
    cfg_write(REG_SETPOINT, 32'h0000_8000);
    cfg_write(REG_FLOOR, 32'd0);
    cfg_write(REG_CEIL, 32'd0);
    pending_meas.push_back(16'sh8000);
    pending_meas.push_back(16'sh0000);
    drain();

    // random settings; measurements mostly track the setpoint
    for (int p = 0; p < 12; p++) begin
      case ($urandom_range(0, 3))
        0:       kp_w = 32'd0;
        1:       kp_w = $urandom_range(0, 1 << 20);
        2:       kp_w = $urandom();
        default: kp_w = 32'h00FF_FFFF;
      endcase
      case ($urandom_range(0, 3))
        0:       ki_w = 32'd0;
        1:       ki_w = $urandom_range(0, 4096);
        2:       ki_w = $urandom();
        default: ki_w = 32'h00FF_FFFF;
      endcase
      case ($urandom_range(0, 3))
        0: begin
          lo_w = FLOOR_RST;
          hi_w = CEIL_RST;
        end
        1: begin
          lo_w = $urandom_range(0, 2000);
          hi_w = $urandom_range(2000, 65535);
        end
        2: begin
          lo_w = $urandom();
          hi_w = $urandom();
        end
        default: begin
          lo_w = 16'd0;
          hi_w = 16'hFFFF;
        end
      endcase
      cfg_write(REG_SETPOINT, $urandom());
      cfg_write(REG_PROP, {8'($urandom()), kp_w[23:0]});
      cfg_write(REG_INTEG, {8'($urandom()), ki_w[23:0]});
      cfg_write(REG_MODE, {30'($urandom()), 2'($urandom_range(0, 3))});
      cfg_write(REG_FLOOR, {16'($urandom()), lo_w});
      cfg_write(REG_CEIL, {16'($urandom()), hi_w});
      for (int k = 0; k < 125; k++) begin
        noise = 16'($urandom_range(0, 1023)) - 16'sd512;
        if ($urandom_range(0, 3) == 0) begin
          pending_meas.push_back(16'($urandom()));
        end else if (mode_m == MODE_BOOST) begin
          pending_meas.push_back(noise - setpoint_m);
        end else begin
          pending_meas.push_back(setpoint_m - noise);
        end
      end
      drain();
    end

    // integral runs into its upper limit, then its lower one
    cfg_write(REG_SETPOINT, 32'h0000_7FFF);
    cfg_write(REG_PROP, 32'd0);
    cfg_write(REG_INTEG, 32'd1);
    cfg_write(REG_MODE, 32'(MODE_BUCK));
    cfg_write(REG_FLOOR, 32'd0);
    cfg_write(REG_CEIL, 32'd65535);
    n = int'((INTEG_TOP - longint'(integ_m)) / 65535) + 20;
    repeat (n) pending_meas.push_back(16'sh8000);
    drain();
    cfg_write(REG_SETPOINT, 32'h0000_8000);
    cfg_write(REG_MODE, 32'(MODE_BOOST));
    n = int'((longint'(integ_m) - INTEG_BOTTOM) / 65536) + 20;
    repeat (n) pending_meas.push_back(16'sh8000);
    drain();
    // proportional term offsets the pinned integral back into range
    cfg_write(REG_SETPOINT, 32'h0000_7FFF);
    cfg_write(REG_MODE, 32'(MODE_BUCK));
    cfg_write(REG_PROP, 32'd32770);
    repeat (3) pending_meas.push_back(16'sh8000);
    drain();

    if (errors == 0) begin
      $display("pi_current_duty_controller verification clean");
    end else begin
      $display("pi_current_duty_controller verification failed");
    end
    $finish;
  end

endmodule
